[src/call_timing_profiler_stack_unit_assert.svh]
// assertion macros for the call profiler, sampled on clk_i, off while rst_ni is low
`ifndef CALL_TIMING_PROFILER_STACK_UNIT_ASSERT_SVH
`define CALL_TIMING_PROFILER_STACK_UNIT_ASSERT_SVH

// condition holds at every edge
`define CTPS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define CTPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define CTPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ctps_pkg.sv]
package ctps_pkg;

  // default sizes
  localparam int unsigned STACK_DEPTH_DEF  = 1024;
  localparam int unsigned STAT_ENTRIES_DEF = 256;

  typedef enum logic {
    CMD_ENTER = 1'b0,
    CMD_LEAVE = 1'b1
  } ctps_cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_MISMATCH = 2'd3
  } ctps_status_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_CALC,
    FSM_UPDATE
  } ctps_state_e;

  // input transfer
  typedef struct packed {
    logic        cmd;
    logic [7:0]  stat_id;
    logic [63:0] timestamp;
  } ctps_in_t;

  // output transfer
  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] depth;
    logic [63:0] elapsed;
    logic [63:0] child_time;
    logic [63:0] call_count;
    logic [63:0] total_sum;
    logic [63:0] total_min;
    logic [63:0] total_max;
    logic [63:0] nested_sum;
    logic [63:0] nested_min;
    logic [63:0] nested_max;
  } ctps_out_t;

  // one call stack frame
  typedef struct packed {
    logic [7:0]  stat_id;
    logic [63:0] begin_ts;
    logic [63:0] children;
  } ctps_frame_t;

  // one statistics entry
  typedef struct packed {
    logic [63:0] call_count;
    logic [63:0] total_sum;
    logic [63:0] total_min;
    logic [63:0] total_max;
    logic [63:0] nested_sum;
    logic [63:0] nested_min;
    logic [63:0] nested_max;
  } ctps_stat_t;

  localparam ctps_stat_t STAT_RESET = '{
    call_count: 64'd0,
    total_sum:  64'd0,
    total_min:  '1,
    total_max:  64'd0,
    nested_sum: 64'd0,
    nested_min: '1,
    nested_max: 64'd0
  };

endpackage

[src/ctps_frame_ram.sv]
module ctps_frame_ram #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  ctps_pkg::ctps_frame_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_a_i,
  input  logic [AW-1:0]        raddr_b_i,
  output ctps_pkg::ctps_frame_t rdata_a_o,
  output ctps_pkg::ctps_frame_t rdata_b_o
);
  import ctps_pkg::*;

  ctps_frame_t mem_q [DEPTH];
  ctps_frame_t rdata_a_q;
  ctps_frame_t rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports, data held while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[src/ctps_stat_ram.sv]
module ctps_stat_ram #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  ctps_pkg::ctps_stat_t wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output ctps_pkg::ctps_stat_t rdata_o
);
  import ctps_pkg::*;

  ctps_stat_t mem_q [DEPTH];
  ctps_stat_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, data held while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/ctps_stat_upd.sv]
module ctps_stat_upd (
  input  ctps_pkg::ctps_stat_t old_i,
  input  logic [63:0]         elapsed_i,
  input  logic [63:0]         child_i,
  output ctps_pkg::ctps_stat_t new_o
);
  import ctps_pkg::*;

  // count, wrapping sums, running min and max for both times
  always_comb begin
    new_o.call_count = old_i.call_count + 64'd1;
    new_o.total_sum  = old_i.total_sum + elapsed_i;
    new_o.total_min  = (elapsed_i < old_i.total_min) ? elapsed_i : old_i.total_min;
    new_o.total_max  = (elapsed_i > old_i.total_max) ? elapsed_i : old_i.total_max;
    new_o.nested_sum = old_i.nested_sum + child_i;
    new_o.nested_min = (child_i < old_i.nested_min) ? child_i : old_i.nested_min;
    new_o.nested_max = (child_i > old_i.nested_max) ? child_i : old_i.nested_max;
  end

endmodule

[src/call_timing_profiler_stack_unit.sv]
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o   | in_i  (cmd, stat_id, timestamp)
// out     | output    | out_valid_o / out_ready_i | out_o (status, depth, times, stats)
//
// enter is accepted, then updated; leave is accepted, then reads frame and statistics, then updates and writes back
// one item at a time; an enter writes a frame, a leave reads both memories and writes them back
// after reset a clearing pass writes every entry of the statistics memory
// a result waiting on out_ready_i holds the item in its last cycle; the next item is
// accepted once that result sits in the output register
`include "call_timing_profiler_stack_unit_assert.svh"

module call_timing_profiler_stack_unit #(
  parameter int unsigned STACK_DEPTH  = ctps_pkg::STACK_DEPTH_DEF,
  parameter int unsigned STAT_ENTRIES = ctps_pkg::STAT_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ctps_pkg::ctps_in_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ctps_pkg::ctps_out_t out_o
);
  import ctps_pkg::*;

  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SDW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIW = (STAT_ENTRIES > 1) ? $clog2(STAT_ENTRIES) : 1;

  ctps_state_e state_q, state_d;
  logic [SDW-1:0] depth_q, depth_d;
  logic [SIW-1:0] clr_q, clr_d;

  // item registers
  logic           cmd_q;
  logic [7:0]     sid_q;
  logic [63:0]    ts_q;
  logic [SIW-1:0] eidx_q;
  logic [63:0]    elapsed_q;
  logic [63:0]    child_q;
  logic           mismatch_q;

  ctps_out_t out_q;
  logic      out_valid_q;

  logic in_fire, out_free, load, rd_en;
  logic [24:0]    sid_rem;
  logic [SIW-1:0] eidx;
  logic [SDW-1:0] depth_m1, depth_m2;

  // memory ports
  logic           fr_we;
  logic [SAW-1:0] fr_waddr;
  ctps_frame_t    fr_wdata, fr_top, fr_parent;
  logic           st_we;
  logic [SIW-1:0] st_waddr;
  ctps_stat_t     st_wdata, st_rd, st_new;

  // result of the update cycle
  ctps_status_e   status;
  logic           enter_ok, leave_ok;
  logic [SDW-1:0] depth_nxt;
  logic [31:0]    depth_wide;
  ctps_out_t      res;

  assign in_ready_o = (state_q == FSM_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load       = (state_q == FSM_UPDATE) && out_free;
  assign rd_en      = in_fire && (in_i.cmd == CMD_LEAVE);

  // statistic index: stat_id modulo entries, restoring subtraction over 8 bits
  always_comb begin
    sid_rem = 25'(in_i.stat_id);
    for (int k = 7; k >= 0; k--) begin
      if (sid_rem >= (25'(STAT_ENTRIES) << k)) begin
        sid_rem = sid_rem - (25'(STAT_ENTRIES) << k);
      end
    end
    eidx = sid_rem[SIW-1:0];
  end

  // top and parent frame addresses
  assign depth_m1 = depth_q - SDW'(1);
  assign depth_m2 = depth_q - SDW'(2);

  ctps_frame_ram #(
    .DEPTH (STACK_DEPTH)
  ) u_frame_ram (
    .clk_i     (clk_i),
    .we_i      (fr_we),
    .waddr_i   (fr_waddr),
    .wdata_i   (fr_wdata),
    .re_i      (rd_en),
    .raddr_a_i (depth_m1[SAW-1:0]),
    .raddr_b_i (depth_m2[SAW-1:0]),
    .rdata_a_o (fr_top),
    .rdata_b_o (fr_parent)
  );

  ctps_stat_ram #(
    .DEPTH (STAT_ENTRIES)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (rd_en),
    .raddr_i (eidx),
    .rdata_o (st_rd)
  );

  ctps_stat_upd u_stat_upd (
    .old_i     (st_rd),
    .elapsed_i (elapsed_q),
    .child_i   (child_q),
    .new_o     (st_new)
  );

  // outcome of the item in the update cycle
  always_comb begin
    if (cmd_q == CMD_ENTER) begin
      status = (depth_q >= SDW'(STACK_DEPTH)) ? ST_FULL : ST_OK;
    end else if (depth_q == '0) begin
      status = ST_EMPTY;
    end else if (mismatch_q) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_OK;
    end
    enter_ok = (cmd_q == CMD_ENTER) && (status == ST_OK);
    leave_ok = (cmd_q == CMD_LEAVE) && (status == ST_OK);
    if (enter_ok) begin
      depth_nxt = depth_q + SDW'(1);
    end else if (leave_ok) begin
      depth_nxt = depth_m1;
    end else begin
      depth_nxt = depth_q;
    end
    depth_wide = 32'(depth_nxt);

    res            = '0;
    res.status     = status;
    res.depth      = depth_wide[10:0];
    if (leave_ok) begin
      res.elapsed    = elapsed_q;
      res.child_time = child_q;
      res.call_count = st_new.call_count;
      res.total_sum  = st_new.total_sum;
      res.total_min  = st_new.total_min;
      res.total_max  = st_new.total_max;
      res.nested_sum = st_new.nested_sum;
      res.nested_min = st_new.nested_min;
      res.nested_max = st_new.nested_max;
    end
  end

  // state machine and memory write control
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    depth_d  = depth_q;
    st_we    = 1'b0;
    st_waddr = eidx_q;
    st_wdata = st_new;
    fr_we    = 1'b0;
    fr_waddr = depth_q[SAW-1:0];
    fr_wdata = '{stat_id: sid_q, begin_ts: ts_q, children: 64'd0};
    case (state_q)
      FSM_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = STAT_RESET;
        if (clr_q == SIW'(STAT_ENTRIES - 1)) begin
          state_d = FSM_IDLE;
        end else begin
          clr_d = clr_q + SIW'(1);
        end
      end
      FSM_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.cmd == CMD_LEAVE) ? FSM_CALC : FSM_UPDATE;
        end
      end
      FSM_CALC: begin
        state_d = FSM_UPDATE;
      end
      FSM_UPDATE: begin
        if (out_free) begin
          state_d = FSM_IDLE;
          depth_d = depth_nxt;
          if (enter_ok) begin
            fr_we = 1'b1;
          end
          if (leave_ok) begin
            st_we = 1'b1;
            // credit the parent frame with this call's time
            if (depth_q > SDW'(1)) begin
              fr_we    = 1'b1;
              fr_waddr = depth_m2[SAW-1:0];
              fr_wdata = '{stat_id:  fr_parent.stat_id,
                           begin_ts: fr_parent.begin_ts,
                           children: fr_parent.children + elapsed_q};
            end
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_CLEAR;
      clr_q       <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      depth_q <= depth_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture, top frame evaluation and result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_i.cmd;
      sid_q  <= in_i.stat_id;
      ts_q   <= in_i.timestamp;
      eidx_q <= eidx;
    end
    if (state_q == FSM_CALC) begin
      elapsed_q  <= ts_q - fr_top.begin_ts;
      child_q    <= fr_top.children;
      mismatch_q <= (fr_top.stat_id != sid_q);
    end
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  `CTPS_ASSERT(a_depth_bound, depth_q <= SDW'(STACK_DEPTH), "stack depth beyond capacity")
  `CTPS_ASSERT_IMPL(a_result_from_update, $rose(out_valid_o), $past(state_q) == FSM_UPDATE, "result loaded outside the update cycle")
  `CTPS_ASSERT_NEXT(a_error_keeps_depth, load && (res.status != ST_OK), depth_q == $past(depth_q), "faulted event changed the stack depth")

endmodule
